/* rtl/k_combination_enumerator_defines.svh */
// Assertion macros shared by the k-combination enumerator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef K_COMBINATION_ENUMERATOR_DEFINES_SVH
`define K_COMBINATION_ENUMERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KCE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kce_pkg.sv */
// Package for the k-combination enumerator: sizes, widths and shared types.
// Depends on nothing; imported by every module of the block.
package kce_pkg;

  localparam int MAX_N  = 64;
  localparam int MAX_R  = 16;
  localparam int ELEM_W = $clog2(MAX_N);
  localparam int IDX_W  = $clog2(MAX_R);
  localparam int N_W    = $clog2(MAX_N + 1);
  localparam int R_W    = $clog2(MAX_R + 1);

  typedef enum logic [0:0] {
    REG_SET_SIZE     = 1'b0,
    REG_CHOOSE_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              has_comb;
    logic              empty;
    logic [IDX_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
    logic              last;
  } result_t;

endpackage

/* rtl/kce_chosen_ram.sv */
// Synchronous memory holding the current combination, one element per entry.
// One write and one read port, read data registered. Depends on kce_pkg.
module kce_chosen_ram
  import kce_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [ELEM_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [ELEM_W-1:0] rd_data
);

  logic [ELEM_W-1:0] mem [MAX_R];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/kce_out_reg.sv */
// Output register for result transactions; frees the sequencer from the receiver.
// Depends on kce_pkg for the result structure.
module kce_out_reg
  import kce_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_q
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_q <= res;
    end
  end

endmodule

/* rtl/kce_seq.sv */
// Sequencer of the k-combination enumerator: scans the stored combination for
// the pivot, then rewrites and emits it, or emits a single status result.
// Depends on kce_pkg and kce_chosen_ram ports, and on the assertion macros header.
`include "k_combination_enumerator_defines.svh"

module kce_seq
  import kce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [N_W-1:0]    set_size,
  input  logic [R_W-1:0]    choose_count,
  input  logic              cfg_write,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              next_request,
  input  logic              res_free,
  output logic              res_load,
  output result_t           res,
  output logic              ram_wr_en,
  output logic [IDX_W-1:0]  ram_wr_addr,
  output logic [ELEM_W-1:0] ram_wr_data,
  output logic              ram_rd_en,
  output logic [IDX_W-1:0]  ram_rd_addr,
  input  logic [ELEM_W-1:0] ram_rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_EMIT,
    S_SINGLE
  } state_t;

  state_t            state;
  logic              running;
  logic              running_next;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  pivot;
  logic [ELEM_W-1:0] base;
  logic              single_has;
  logic              single_empty;

  logic              accept;
  logic              sizes_bad;
  logic              r_zero;
  logic [IDX_W-1:0]  last_idx;
  logic [N_W-1:0]    ceiling;
  logic              mismatch;
  logic [ELEM_W-1:0] emit_val;
  logic              wr_in_range;
  logic              last_ok;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready && next_request;
  assign sizes_bad = ({2'b00, choose_count} > set_size)
                     || (choose_count > R_W'(MAX_R))
                     || (set_size > N_W'(MAX_N));
  assign r_zero    = (choose_count == '0);
  assign last_idx  = IDX_W'(choose_count - R_W'(1));
  assign ceiling   = set_size - N_W'(choose_count) + N_W'(pos);
  assign mismatch  = (N_W'(ram_rd_data) != ceiling);
  assign emit_val  = (pos < pivot) ? ram_rd_data : base + ELEM_W'(pos);

  assign wr_in_range = ({1'b0, ram_wr_addr} < choose_count);
  assign last_ok     = (state != S_EMIT) || (res.last == (pos == last_idx));

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = pos;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pos;
    ram_wr_data = emit_val;
    res_load    = 1'b0;
    res         = '0;
    case (state)
      S_IDLE: begin
        if (accept && !sizes_bad && running && !r_zero) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = last_idx;
        end
      end
      S_FIND: begin
        if (mismatch) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = '0;
        end else if (pos != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = pos - IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (res_free) begin
          res_load     = 1'b1;
          res.has_comb = 1'b1;
          res.pos      = pos;
          res.elem     = emit_val;
          res.last     = (pos == last_idx);
          ram_wr_en    = (pos >= pivot);
          if (pos != last_idx) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos + IDX_W'(1);
          end
        end
      end
      S_SINGLE: begin
        if (res_free) begin
          res_load     = 1'b1;
          res.has_comb = single_has;
          res.empty    = single_empty;
          res.last     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    running_next = running;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sizes_bad) begin
            running_next = 1'b0;
          end else if (!running) begin
            running_next = 1'b1;
          end else if (r_zero) begin
            running_next = 1'b0;
          end
        end
      end
      S_FIND: begin
        if (!mismatch && pos == '0) begin
          running_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (cfg_write) begin
      running_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running      <= 1'b0;
      pos          <= '0;
      pivot        <= '0;
      base         <= '0;
      single_has   <= 1'b0;
      single_empty <= 1'b0;
    end else begin
      running <= running_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (sizes_bad) begin
              single_has   <= 1'b0;
              single_empty <= 1'b0;
              state        <= S_SINGLE;
            end else if (!running) begin
              if (r_zero) begin
                single_has   <= 1'b1;
                single_empty <= 1'b1;
                state        <= S_SINGLE;
              end else begin
                pos   <= '0;
                pivot <= '0;
                base  <= '0;
                state <= S_EMIT;
              end
            end else if (r_zero) begin
              single_has   <= 1'b0;
              single_empty <= 1'b0;
              state        <= S_SINGLE;
            end else begin
              pos   <= last_idx;
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (mismatch) begin
            pivot <= pos;
            base  <= ram_rd_data + ELEM_W'(1) - ELEM_W'(pos);
            pos   <= '0;
            state <= S_EMIT;
          end else if (pos == '0) begin
            single_has   <= 1'b0;
            single_empty <= 1'b0;
            state        <= S_SINGLE;
          end else begin
            pos <= pos - IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (res_free) begin
            if (pos == last_idx) begin
              state <= S_IDLE;
            end else begin
              pos <= pos + IDX_W'(1);
            end
          end
        end
        S_SINGLE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KCE_ASSERT_IMPL(a_load_when_free, clk, rst, res_load, res_free, "load into a busy register")
  `KCE_ASSERT_IMPL(a_write_in_range, clk, rst, ram_wr_en, wr_in_range, "write out of range")
  `KCE_ASSERT_NEXT(a_busy_after_request, clk, rst, accept, !in_ready, "request did not start")
  `KCE_ASSERT_IMPL(a_last_at_end, clk, rst, res_load, last_ok, "last marker misplaced")

endmodule

/* rtl/k_combination_enumerator.sv */
// Top level of the lexicographic k-combination enumerator.
// Depends on kce_pkg, kce_chosen_ram, kce_out_reg and kce_seq.
//
// Usage: write set_size (index 0) and choose_count (index 1) through the
// configuration port while the block is idle; either write restarts the round.
// Each request transaction on the input channel returns the next combination
// as choose_count result transactions, one element each in increasing order,
// with last set on the final one. When the round is over, or the sizes are
// invalid, one result with has_combination low is given; when choose_count is
// zero the round holds a single empty combination.
// On the first combination of a round the sequencer goes straight from the
// accepted request to emitting; otherwise it first scans the stored entries
// for the pivot from the last one downward, one memory read per cycle.
// Throughput: elements stream at one per cycle while the output register
// is free to take them; the pivot scan, when there is one, comes first.
// Reset clears the sizes to zero and ends any round; the stored combination
// is rewritten at the start of each round. A stalled receiver holds the
// output register and the sequencer waits on it; new requests are taken
// once the previous one has emitted all its results.
module k_combination_enumerator
  import kce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [0:0]        cfg_index,
  input  logic [N_W-1:0]    cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              next_request,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_combination,
  output logic              is_empty,
  output logic [IDX_W-1:0]  position,
  output logic [ELEM_W-1:0] element,
  output logic              last
);

  logic [N_W-1:0]    set_size;
  logic [R_W-1:0]    choose_count;
  logic              res_free;
  logic              res_load;
  result_t           res;
  result_t           res_q;
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [ELEM_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [ELEM_W-1:0] ram_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size     <= '0;
      choose_count <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SET_SIZE:     set_size     <= cfg_data;
        REG_CHOOSE_COUNT: choose_count <= cfg_data[R_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kce_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .set_size     (set_size),
    .choose_count (choose_count),
    .cfg_write    (cfg_write),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .next_request (next_request),
    .res_free     (res_free),
    .res_load     (res_load),
    .res          (res),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  kce_chosen_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  kce_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .free      (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign has_combination = res_q.has_comb;
  assign is_empty        = res_q.empty;
  assign position        = res_q.pos;
  assign element         = res_q.elem;
  assign last            = res_q.last;

endmodule
